>>> src/ssg_pkg.sv
// Shared types, constants and state encoding for the serial schedule generator.
package ssg_pkg;

    localparam int MaxJobsDef    = 32;
    localparam int NumResDef     = 4;
    localparam int MaxHorizonDef = 256;
    localparam int ResIn         = 4;

    localparam logic [1:0] StatOk      = 2'd0;
    localparam logic [1:0] StatNoSlot  = 2'd1;
    localparam logic [1:0] StatOrder   = 2'd2;

    localparam logic [2:0] RegCap0    = 3'd0;
    localparam logic [2:0] RegCap1    = 3'd1;
    localparam logic [2:0] RegCap2    = 3'd2;
    localparam logic [2:0] RegCap3    = 3'd3;
    localparam logic [2:0] RegHorizon = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_EST,
        ST_FWD_INIT,
        ST_FWD_RD,
        ST_FWD_EVAL,
        ST_BWD_INIT,
        ST_COMMIT_RD,
        ST_COMMIT_WR,
        ST_DONE,
        ST_OUT
    } t_state;

    // Controller -> datapath commands.
    typedef struct packed {
        logic load;        // capture input transaction
        logic check;       // evaluate order checks
        logic est_step;    // one predecessor finish per cycle
        logic fwd_init;    // t <- est, tau <- t
        logic bwd_init;    // t <- horizon - d, tau <- t
        logic scan_rd;     // issue usage read at tau
        logic scan_eval;   // compare read data; advance
        logic commit_init; // tau <- start
        logic commit_rd;   // read usage at tau
        logic commit_wr;   // write usage + demand at tau
        logic finish_ok;   // record placement
        logic set_nslot;   // record no-slot error
        logic zero_place;  // zero-duration placement
        logic clear_step;  // clear one usage row
        logic clear_init;  // start clearing pass
        logic out_load;    // present result
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic err_sticky;  // error already present
        logic order_bad;   // order check failed
        logic dur_zero;
        logic est_done;
        logic fits_done;   // window checked ok through duration
        logic fits_fail;   // conflict at current tau
        logic fwd_exhaust; // forward t reached horizon
        logic bwd_exhaust; // backward t below zero
        logic commit_done;
        logic clear_done;
        logic last_flag;
    } t_sts;

endpackage

>>> src/ssg_if.sv
// Valid/ready channel interfaces for job input and schedule result.
interface ssg_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] job_id;
    logic [7:0] duration;
    logic [7:0] demand_res0;
    logic [7:0] demand_res1;
    logic [7:0] demand_res2;
    logic [7:0] demand_res3;
    logic [31:0] pred_mask;
    logic       last_job;
    modport source (output valid, job_id, duration, demand_res0, demand_res1,
                    demand_res2, demand_res3, pred_mask, last_job, input ready);
    modport sink (input valid, job_id, duration, demand_res0, demand_res1,
                  demand_res2, demand_res3, pred_mask, last_job, output ready);
endinterface

interface ssg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_time;
    logic [8:0] finish_time;
    logic [1:0] status;
    logic [8:0] makespan;
    logic       last;
    modport source (output valid, start_time, finish_time, status, makespan, last,
                    input ready);
    modport sink (input valid, start_time, finish_time, status, makespan, last,
                  output ready);
endinterface

>>> src/ssg_ctrl.sv
// Controller state machine sequencing check, scan, commit and clear.
module ssg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ssg_pkg::t_sts   i_sts,
    output ssg_pkg::t_cmd   o_cmd
);
    import ssg_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.err_sticky || i_sts.order_bad) begin
                    n_state = ST_DONE;
                end else if (i_sts.dur_zero) begin
                    o_cmd.zero_place = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_EST;
                end
            end
            ST_EST: begin
                o_cmd.est_step = 1'b1;
                if (i_sts.est_done) begin
                    n_state = ST_FWD_INIT;
                end
            end
            ST_FWD_INIT: begin
                o_cmd.fwd_init = 1'b1;
                n_state = ST_FWD_RD;
            end
            ST_FWD_RD: begin
                if (i_sts.fwd_exhaust) begin
                    n_state = ST_BWD_INIT;
                end else if (i_sts.bwd_exhaust) begin
                    o_cmd.set_nslot = 1'b1;
                    n_state = ST_DONE;
                end else if (i_sts.fits_done) begin
                    o_cmd.commit_init = 1'b1;
                    n_state = ST_COMMIT_RD;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state = ST_FWD_EVAL;
                end
            end
            ST_FWD_EVAL: begin
                o_cmd.scan_eval = 1'b1;
                n_state = ST_FWD_RD;
            end
            ST_BWD_INIT: begin
                o_cmd.bwd_init = 1'b1;
                n_state = ST_FWD_RD;
            end
            ST_COMMIT_RD: begin
                o_cmd.commit_rd = 1'b1;
                n_state = ST_COMMIT_WR;
            end
            ST_COMMIT_WR: begin
                o_cmd.commit_wr = 1'b1;
                if (i_sts.commit_done) begin
                    o_cmd.finish_ok = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_COMMIT_RD;
                end
            end
            ST_DONE: begin
                o_cmd.out_load = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last_flag) begin
                        o_cmd.clear_init = 1'b1;
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

endmodule

>>> src/ssg_datapath.sv
// Datapath: job registers, usage memory, finish table, scan and commit logic.
module ssg_datapath #(
    parameter int MAX_JOBS    = ssg_pkg::MaxJobsDef,
    parameter int NUM_RES     = ssg_pkg::NumResDef,
    parameter int MAX_HORIZON = ssg_pkg::MaxHorizonDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssg_pkg::t_cmd i_cmd,
    output ssg_pkg::t_sts o_sts,
    input  logic [4:0]    i_job_id,
    input  logic [7:0]    i_duration,
    input  logic [7:0]    i_demand [ssg_pkg::ResIn],
    input  logic [31:0]   i_pred_mask,
    input  logic          i_last_job,
    input  logic [7:0]    i_cap [ssg_pkg::ResIn],
    input  logic [8:0]    i_horizon,
    output logic [7:0]    o_start_time,
    output logic [8:0]    o_finish_time,
    output logic [1:0]    o_status,
    output logic [8:0]    o_makespan,
    output logic          o_last
);
    import ssg_pkg::*;

    localparam int ResUsed = (NUM_RES < ResIn) ? NUM_RES : ResIn;
    localparam int TW      = $clog2(MAX_HORIZON + 1);  // holds horizon itself
    localparam int AW      = $clog2(MAX_HORIZON);
    localparam int JW      = $clog2(MAX_JOBS);
    localparam int MW      = (MAX_JOBS > 32) ? MAX_JOBS : 32;

    // Usage memory: one row holds all used resources of one time slot.
    logic [ResUsed*8-1:0] r_usage [MAX_HORIZON];
    logic [ResUsed*8-1:0] r_rd;
    logic [8:0]           r_fin [MAX_JOBS];

    logic [4:0]  r_id;
    logic [7:0]  r_dur;
    logic [7:0]  r_dem [ResIn];
    logic [31:0] r_pred;
    logic        r_last;
    logic [MW-1:0] r_placed;
    logic [8:0]  r_mksp;
    logic [1:0]  r_err;
    logic [8:0]  r_est;
    logic [JW:0] r_j;        // predecessor index, counts to MAX_JOBS
    logic [8:0]  r_fin_rd;
    logic        r_fin_vld;
    logic signed [TW+1:0] r_t;   // candidate start
    logic [TW:0] r_tau;          // slot under test
    logic        r_bwd;
    logic [7:0]  r_start;
    logic [8:0]  r_finish;
    logic        r_ok;
    logic [AW:0] r_clr;
    logic [TW-1:0] w_hor;
    logic        w_bad;
    logic        w_fit;
    logic [TW+1:0] w_end;

    // Effective horizon: 0 reads as 1, saturate to MAX_HORIZON.
    always_comb begin
        if (i_horizon == 9'd0) begin
            w_hor = TW'(1);
        end else if (32'(i_horizon) > 32'(MAX_HORIZON)) begin
            w_hor = TW'(MAX_HORIZON);
        end else begin
            w_hor = TW'(i_horizon);
        end
    end

    always_comb begin
        w_bad = 1'b0;
        if (32'(r_id) >= 32'(MAX_JOBS)) begin
            w_bad = 1'b1;
        end else if (r_placed[r_id[JW-1:0]]) begin
            w_bad = 1'b1;
        end
        if ((MW'(r_pred) & ~r_placed) != '0) begin
            w_bad = 1'b1;
        end
    end

    always_comb begin
        w_fit = 1'b1;
        for (int k = 0; k < ResUsed; k++) begin
            if ({1'b0, r_rd[k*8 +: 8]} + {1'b0, r_dem[k]} > {1'b0, i_cap[k]}) begin
                w_fit = 1'b0;
            end
        end
    end

    assign w_end = (TW+2)'(r_t) + (TW+2)'(r_dur);

    always_comb begin
        o_sts             = '0;
        o_sts.err_sticky  = (r_err != StatOk);
        o_sts.order_bad   = w_bad;
        o_sts.dur_zero    = (r_dur == 8'd0);
        o_sts.est_done    = (32'(r_j) >= 32'(MAX_JOBS)) && !r_fin_vld;
        o_sts.fwd_exhaust = !r_bwd && (r_t >= $signed({2'b00, w_hor}));
        o_sts.bwd_exhaust = r_bwd && (r_t < 0);
        // window [t, t+d) passed when tau reached t+d and fits in horizon
        o_sts.fits_done   = ((TW+2)'(r_tau) == w_end) &&
                            (w_end <= (TW+2)'(w_hor));
        o_sts.fits_fail   = !w_fit;
        o_sts.commit_done = ((9'(r_tau) + 9'd1) == r_finish);
        o_sts.clear_done  = (32'(r_clr) >= 32'(MAX_HORIZON));
        o_sts.last_flag   = r_last;
    end

    // usage memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && (32'(r_clr) < 32'(MAX_HORIZON))) begin
            r_usage[r_clr[AW-1:0]] <= '0;
        end else if (i_cmd.commit_wr) begin
            for (int k = 0; k < ResUsed; k++) begin
                r_usage[r_tau[AW-1:0]][k*8 +: 8] <= r_rd[k*8 +: 8] + r_dem[k];
            end
        end
        if (i_cmd.scan_rd || i_cmd.commit_rd) begin
            r_rd <= r_usage[r_tau[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_place) begin
            r_fin[r_id[JW-1:0]] <= 9'd0;
        end else if (i_cmd.finish_ok) begin
            r_fin[r_id[JW-1:0]] <= r_finish;
        end
        if (i_cmd.est_step && 32'(r_j) < 32'(MAX_JOBS)) begin
            r_fin_rd <= r_fin[r_j[JW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id   <= i_job_id;
            r_dur  <= i_duration;
            r_dem  <= i_demand;
            r_pred <= i_pred_mask;
            r_last <= i_last_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed  <= '0;
            r_mksp    <= '0;
            r_err     <= StatOk;
            r_clr     <= '0;
            r_j       <= '0;
            r_fin_vld <= 1'b0;
            r_ok      <= 1'b0;
            r_bwd     <= 1'b0;
        end else begin
            if (i_cmd.clear_init) begin
                r_clr    <= '0;
                r_placed <= '0;
                r_mksp   <= '0;
                r_err    <= StatOk;
            end else if (i_cmd.clear_step && !o_sts.clear_done) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.load) begin
                r_j       <= '0;
                r_fin_vld <= 1'b0;
                r_est     <= '0;
                r_ok      <= 1'b0;
                r_bwd     <= 1'b0;
            end
            if (i_cmd.check) begin
                if (r_err == StatOk && w_bad) begin
                    r_err <= StatOrder;
                end
                if (r_err == StatOk && !w_bad && r_dur == 8'd0) begin
                    r_start  <= '0;
                    r_finish <= '0;
                    r_ok     <= 1'b1;
                end
            end
            if (i_cmd.zero_place) begin
                r_placed[r_id[JW-1:0]] <= 1'b1;
            end
            if (i_cmd.est_step) begin
                if (32'(r_j) < 32'(MAX_JOBS)) begin
                    // the mask only names jobs 0..31
                    r_fin_vld <= (32'(r_j) < 32) && r_pred[r_j[4:0]];
                    r_j <= r_j + 1'b1;
                end else begin
                    r_fin_vld <= 1'b0;
                end
                if (r_fin_vld && r_fin_rd > r_est) begin
                    r_est <= r_fin_rd;
                end
            end
            if (i_cmd.fwd_init) begin
                r_t   <= (TW+2)'(r_est);
                r_tau <= (TW+1)'(r_est);
            end
            if (i_cmd.bwd_init) begin
                r_bwd <= 1'b1;
                if ({1'b0, w_hor} >= (TW+1)'(r_dur)) begin
                    r_t   <= $signed((TW+2)'(w_hor) - (TW+2)'(r_dur));
                    r_tau <= (TW+1)'(w_hor) - (TW+1)'(r_dur);
                end else begin
                    r_t   <= '0;
                    r_tau <= '0;
                end
            end
            if (i_cmd.scan_rd) begin
                // window overruns horizon: set tau to all ones; scan_eval rejects it, read data unused
                if (w_end > (TW+2)'(w_hor)) begin
                    r_tau <= '1;
                end
            end
            if (i_cmd.scan_eval) begin
                if (w_end > (TW+2)'(w_hor) || !w_fit) begin
                    if (r_bwd) begin
                        r_t   <= r_t - 1'b1;
                        r_tau <= (TW+1)'(r_t - 1'b1);
                    end else begin
                        r_t   <= r_t + 1'b1;
                        r_tau <= (TW+1)'(r_t + 1'b1);
                    end
                end else begin
                    r_tau <= r_tau + 1'b1;
                end
            end
            if (i_cmd.commit_init) begin
                r_start  <= 8'(r_t);
                r_finish <= 9'(w_end);
                r_tau    <= (TW+1)'(r_t);
                r_ok     <= 1'b1;
            end
            if (i_cmd.commit_wr) begin
                r_tau <= r_tau + 1'b1;
            end
            if (i_cmd.finish_ok) begin
                r_placed[r_id[JW-1:0]] <= 1'b1;
                if (r_finish > r_mksp) begin
                    r_mksp <= r_finish;
                end
            end
            if (i_cmd.set_nslot) begin
                r_err <= StatNoSlot;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_start_time  <= r_ok ? r_start : 8'd0;
            o_finish_time <= r_ok ? r_finish : 9'd0;
            o_status      <= r_ok ? StatOk : r_err;
            o_makespan    <= r_mksp;
            o_last        <= r_last;
        end
    end

endmodule

>>> src/serial_schedule_generator.sv
// Top level of the serial schedule generator: registers, APB port, control and datapath.
// After a job is accepted, an order or sticky error or a zero duration goes straight to the
//   result; else the finish table sets the earliest start, the usage memory is scanned forward,
//   then backward if that fails, the window is committed; a rejected window restarts its reads.
// One job at a time; the next is taken the cycle after the result transaction (after the
//   last job, once a clearing pass ends). Reset: synchronous active low; registers return
//   to defaults, then a clearing pass zeroes the usage memory before the first job.
module serial_schedule_generator #(
    parameter int MAX_JOBS    = ssg_pkg::MaxJobsDef,
    parameter int NUM_RES     = ssg_pkg::NumResDef,
    parameter int MAX_HORIZON = ssg_pkg::MaxHorizonDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssg_in_if.sink      in_ch,
    ssg_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ssg_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [7:0] r_cap [ResIn];
    logic [8:0] r_hor;
    logic [7:0] w_dem [ResIn];
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];

    // configuration registers, written in the APB access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ResIn; k++) begin
                r_cap[k] <= 8'd255;
            end
            r_hor <= 9'd256;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                RegCap0:    r_cap[0] <= pwdata[7:0];
                RegCap1:    r_cap[1] <= pwdata[7:0];
                RegCap2:    r_cap[2] <= pwdata[7:0];
                RegCap3:    r_cap[3] <= pwdata[7:0];
                RegHorizon: r_hor    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            RegCap0:    prdata = {24'd0, r_cap[0]};
            RegCap1:    prdata = {24'd0, r_cap[1]};
            RegCap2:    prdata = {24'd0, r_cap[2]};
            RegCap3:    prdata = {24'd0, r_cap[3]};
            RegHorizon: prdata = {23'd0, r_hor};
            default:    prdata = 32'd0;
        endcase
    end

    assign w_dem[0] = in_ch.demand_res0;
    assign w_dem[1] = in_ch.demand_res1;
    assign w_dem[2] = in_ch.demand_res2;
    assign w_dem[3] = in_ch.demand_res3;

    ssg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ssg_datapath #(
        .MAX_JOBS   (MAX_JOBS),
        .NUM_RES    (NUM_RES),
        .MAX_HORIZON(MAX_HORIZON)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_job_id     (in_ch.job_id),
        .i_duration   (in_ch.duration),
        .i_demand     (w_dem),
        .i_pred_mask  (in_ch.pred_mask),
        .i_last_job   (in_ch.last_job),
        .i_cap        (r_cap),
        .i_horizon    (r_hor),
        .o_start_time (out_ch.start_time),
        .o_finish_time(out_ch.finish_time),
        .o_status     (out_ch.status),
        .o_makespan   (out_ch.makespan),
        .o_last       (out_ch.last)
    );

endmodule

>>> src/ssg_checker.sv
// Port-level assertions for the serial schedule generator and their bind.
module ssg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_start,
    input logic [8:0] i_finish,
    input logic [1:0] i_status,
    input logic [8:0] i_mksp
);
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid)) else $error("input taken while result pending");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != 2'd0) |-> (i_start == 8'd0 && i_finish == 9'd0))
        else $error("failed job has nonzero placement");

    a_mksp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == 2'd0) |-> (i_finish <= i_mksp))
        else $error("makespan below finish");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_finish)))
        else $error("result dropped while stalled");
endmodule

bind serial_schedule_generator ssg_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (in_ch.ready),
    .i_out_valid(out_ch.valid),
    .i_out_ready(out_ch.ready),
    .i_start    (out_ch.start_time),
    .i_finish   (out_ch.finish_time),
    .i_status   (out_ch.status),
    .i_mksp     (out_ch.makespan)
);
